// File: hw/rtl/idt_pkg.sv
`default_nettype none

package idt_pkg;

	localparam int unsigned IndentW = 12;
	localparam int unsigned LevelW  = 6;

	typedef enum logic [1:0] {
		KIND_NONE   = 2'd0,
		KIND_INDENT = 2'd1,
		KIND_DEDENT = 2'd2,
		KIND_EOF    = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ERR_OK    = 2'd0,
		ERR_DEEP  = 2'd1,
		ERR_ALIGN = 2'd2,
		ERR_HALT  = 2'd3
	} err_t;

	typedef enum logic {
		ACT_LINE = 1'b0,
		ACT_END  = 1'b1
	} action_t;

	// Shift command broadcast to every cell of the stack
	typedef enum logic [1:0] {
		OP_HOLD = 2'd0,
		OP_PUSH = 2'd1,
		OP_POP  = 2'd2
	} stk_op_t;

	typedef struct packed {
		action_t             action;
		logic [IndentW-1:0]  indent_width;
	} req_t;

	typedef struct packed {
		kind_t              token_kind;
		err_t               error_code;
		logic [LevelW-1:0]  level;
		logic               last;
	} rsp_t;

endpackage

`default_nettype wire

// File: hw/rtl/idt_cell.sv
`default_nettype none

module idt_cell
	import idt_pkg::*;
#(
	parameter int unsigned WIDTH_BITS = 12
) (
	input  wire logic                  clk,
	input  wire stk_op_t               op,
	input  wire logic [WIDTH_BITS-1:0] above,
	input  wire logic [WIDTH_BITS-1:0] below,
	output logic      [WIDTH_BITS-1:0] val
);

	logic [WIDTH_BITS-1:0] val_q;

	// take from the neighbor nearer the top on push, from the one below on pop
	always_ff @(posedge clk) begin
		unique case (op)
			OP_PUSH: val_q <= above;
			OP_POP:  val_q <= below;
			default: val_q <= val_q;
		endcase
	end

	assign val = val_q;

endmodule

`default_nettype wire

// File: hw/rtl/idt_stack.sv
`default_nettype none

module idt_stack
	import idt_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned WIDTH_BITS  = 12
) (
	input  wire logic                  clk,
	input  wire stk_op_t               op,
	input  wire logic [WIDTH_BITS-1:0] push_width,
	output logic      [WIDTH_BITS-1:0] top_width,
	output logic      [WIDTH_BITS-1:0] next_width
);

	// the bottom entry is always zero and is not stored
	localparam int unsigned NCells = STACK_DEPTH - 1;

	logic [WIDTH_BITS-1:0] vals [NCells];

	for (genvar i = 0; i < NCells; i++) begin : g_cell
		logic [WIDTH_BITS-1:0] above;
		logic [WIDTH_BITS-1:0] below;

		if (i == 0) begin : g_first
			assign above = push_width;
		end else begin : g_mid
			assign above = vals[i-1];
		end

		if (i == NCells - 1) begin : g_last
			assign below = vals[i];
		end else begin : g_inner
			assign below = vals[i+1];
		end

		idt_cell #(
			.WIDTH_BITS(WIDTH_BITS)
		) u_cell (
			.clk  (clk),
			.op   (op),
			.above(above),
			.below(below),
			.val  (vals[i])
		);
	end

	assign top_width = vals[0];

	if (NCells > 1) begin : g_next
		assign next_width = vals[1];
	end else begin : g_no_next
		assign next_width = '0;
	end

endmodule

`default_nettype wire

// File: hw/rtl/indent_dedent_tracker.sv
`default_nettype none

// The first result of an item is registered and shows in the cycle after acceptance.
// An item producing n results occupies the block until its last result is emitted, stalling
//   while the output register is full; each DEDENT is one pop of the cell chain.
// The next item is taken once the last result of the previous one is emitted and the output register has room.
// Reset (arst_n low, asynchronous): stack empty down to its zero bottom, no error, no result.
module indent_dedent_tracker
	import idt_pkg::*;
#(
	parameter int unsigned STACK_DEPTH = 64,
	parameter int unsigned WIDTH_BITS  = 12
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	localparam int unsigned LevW = $clog2(STACK_DEPTH);
	localparam logic [LevW-1:0] MaxLevel = LevW'(STACK_DEPTH - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DEDENT,
		ST_EOF,
		ST_ALIGN
	} state_t;

	state_t                state_q;
	state_t                state_d;
	logic [LevW-1:0]       level_q;
	logic [LevW-1:0]       level_d;
	logic                  error_q;
	logic [WIDTH_BITS-1:0] width_q;
	logic                  rsp_valid_q;
	rsp_t                  rsp_q;

	logic                  rsp_free;
	logic                  accept;
	logic [WIDTH_BITS-1:0] width_in;
	logic [WIDTH_BITS-1:0] cur_w;
	logic [WIDTH_BITS-1:0] cell_top;
	logic [WIDTH_BITS-1:0] cell_next;
	logic [WIDTH_BITS-1:0] top_w;
	logic [WIDTH_BITS-1:0] next_top_w;
	logic [WIDTH_BITS+IndentW-1:0] width_ext;
	logic [LevW+LevelW-1:0]        level_ext;

	stk_op_t               op;
	logic                  emit;
	kind_t                 emit_kind;
	err_t                  emit_err;
	logic                  emit_last;
	logic                  set_err;

	// Mask or zero-extend the incoming width to the stored width
	assign width_ext = {{WIDTH_BITS{1'b0}}, req.indent_width};
	assign width_in  = width_ext[WIDTH_BITS-1:0];

	// Room in the output register for a new result this cycle
	assign rsp_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == ST_IDLE) && rsp_free;
	assign accept    = req_valid && req_ready;

	// During a dedent run compare against the width held from the item
	assign cur_w = (state_q == ST_IDLE) ? width_in : width_q;

	// Top of stack and the entry under it; the bottom level reads as zero
	assign top_w      = (level_q != '0) ? cell_top : '0;
	assign next_top_w = (level_q > LevW'(1)) ? cell_next : '0;

	idt_stack #(
		.STACK_DEPTH(STACK_DEPTH),
		.WIDTH_BITS (WIDTH_BITS)
	) u_stack (
		.clk       (clk),
		.op        (op),
		.push_width(width_in),
		.top_width (cell_top),
		.next_width(cell_next)
	);

	// Decide the result and stack move for this cycle
	always_comb begin
		state_d   = state_q;
		op        = OP_HOLD;
		emit      = 1'b0;
		emit_kind = KIND_NONE;
		emit_err  = ERR_OK;
		emit_last = 1'b1;
		set_err   = 1'b0;

		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					emit = 1'b1;
					if (error_q) begin
						// halted: answer every item with one error result
						emit_err = ERR_HALT;
					end else if (req.action == ACT_END) begin
						if (level_q == '0) begin
							emit_kind = KIND_EOF;
						end else begin
							// close open levels first, EOF comes at the end
							op        = OP_POP;
							emit_kind = KIND_DEDENT;
							emit_last = 1'b0;
							state_d   = ST_EOF;
						end
					end else if (cur_w > top_w) begin
						if (level_q == MaxLevel) begin
							emit_err = ERR_DEEP;
							set_err  = 1'b1;
						end else begin
							op        = OP_PUSH;
							emit_kind = KIND_INDENT;
						end
					end else if (cur_w < top_w) begin
						// first pop of a dedent run; look one entry ahead for the end
						op        = OP_POP;
						emit_kind = KIND_DEDENT;
						emit_last = (next_top_w == cur_w);
						if (next_top_w > cur_w) begin
							state_d = ST_DEDENT;
						end else if (next_top_w < cur_w) begin
							state_d = ST_ALIGN;
						end
					end
				end
			end
			ST_DEDENT: begin
				if (rsp_free) begin
					emit      = 1'b1;
					op        = OP_POP;
					emit_kind = KIND_DEDENT;
					emit_last = (next_top_w == cur_w);
					if (next_top_w < cur_w) begin
						state_d = ST_ALIGN;
					end else if (next_top_w == cur_w) begin
						state_d = ST_IDLE;
					end
				end
			end
			ST_EOF: begin
				if (rsp_free) begin
					emit = 1'b1;
					if (level_q != '0) begin
						op        = OP_POP;
						emit_kind = KIND_DEDENT;
						emit_last = 1'b0;
					end else begin
						emit_kind = KIND_EOF;
						state_d   = ST_IDLE;
					end
				end
			end
			ST_ALIGN: begin
				if (rsp_free) begin
					// new top missed the line's width
					emit     = 1'b1;
					emit_err = ERR_ALIGN;
					set_err  = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_comb begin
		unique case (op)
			OP_PUSH: level_d = level_q + LevW'(1);
			OP_POP:  level_d = level_q - LevW'(1);
			default: level_d = level_q;
		endcase
	end

	// Output level field is the low bits of the open-level count
	assign level_ext = {{LevelW{1'b0}}, level_d};

	// State, level, sticky error, held width and the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			level_q     <= '0;
			error_q     <= 1'b0;
			width_q     <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			state_q <= state_d;
			level_q <= level_d;
			if (set_err) begin
				error_q <= 1'b1;
			end
			if (accept) begin
				width_q <= width_in;
			end
			if (emit) begin
				rsp_valid_q      <= 1'b1;
				rsp_q.token_kind <= emit_kind;
				rsp_q.error_code <= emit_err;
				rsp_q.level      <= level_ext[LevelW-1:0];
				rsp_q.last       <= emit_last;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire
